FILE: hdl/vwtr_pkg.sv
// Shared types and constants for the proportional font glyph blitter.
// No dependencies; imported by every module of the block but vwtr_width_mem.
package vwtr_pkg;

  localparam int PIX_W = 32;     // pixels in one output row span
  localparam int BANKS = 4;      // bitmap banks, one byte lane each
  localparam logic [6:0] CODE_SPACE = 7'h20;
  localparam logic [7:0] WIDTH_SAT = 8'd32;

  typedef enum logic [1:0] {
    MODE_WIDTH  = 2'd0,
    MODE_BITMAP = 2'd1,
    MODE_START  = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_FONT_HEIGHT = 3'd0,
    CFG_ROW_BYTES   = 3'd1,
    CFG_SCREEN_W    = 3'd2,
    CFG_SCREEN_H    = 3'd3,
    CFG_BACKGROUND  = 3'd4,
    CFG_KEY         = 3'd5
  } cfg_idx_e;

  // One row read in flight towards the output register
  typedef struct packed {
    logic [12:0]      x;
    logic [12:0]      y;
    logic [5:0]       width;
    logic [PIX_W-1:0] wmask;
    logic [BANKS-1:0] byte_ok;
    logic [1:0]       base_lo;
    logic             opaque;
    logic             last;
  } span_req_t;

endpackage

FILE: hdl/variable_width_text_renderer.sv
// Proportional font glyph blitter, top level: configuration registers,
// cursor state, item sequencer. Depends on vwtr_pkg, vwtr_width_mem,
// vwtr_bitmap_mem and vwtr_span_out.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+-------------------------------------------
//  config  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  input   | in_valid_i/in_ready_o   | mode, glyph_slot, byte_offset, load_value,
//          |                         | start_x, start_y, char_code
//  result  | out_valid_o/out_ready_i | span_x, span_y, span_width, pixel_mask,
//          |                         | opaque, last_row
//
// A printed character goes through the wrap check and width read, then the
// width is taken, then one bitmap row per cycle from the banked store while
// the output stage is free (rows = font height, at most 32). Output stalls
// hold back row reads; the input is taken again once the last row read is
// issued. Font memories have no reset: read only loaded entries.
// Configuration is always ready; write it only while the block is idle.
module variable_width_text_renderer
  import vwtr_pkg::*;
#(
  parameter int GLYPH_COUNT   = 96,
  parameter int MAX_ROWS      = 32,
  parameter int MAX_ROW_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  glyph_slot_i,
  input  logic [6:0]  byte_offset_i,
  input  logic [7:0]  load_value_i,
  input  logic [11:0] start_x_i,
  input  logic [11:0] start_y_i,
  input  logic [6:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] span_x_o,
  output logic [12:0] span_y_o,
  output logic [5:0]  span_width_o,
  output logic [31:0] pixel_mask_o,
  output logic        opaque_o,
  output logic        last_row_o
);

  localparam int GLYPH_BYTES = MAX_ROWS * MAX_ROW_BYTES;
  localparam int STORE_BYTES = (GLYPH_BYTES < 128) ? GLYPH_BYTES : 128;
  localparam int WPG         = (STORE_BYTES + BANKS - 1) / BANKS;
  localparam int BANK_DEPTH  = GLYPH_COUNT * WPG;
  localparam int BAW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int SW          = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_LIMIT   = (MAX_ROWS < 32) ? MAX_ROWS : 32;
  localparam int RW          = $clog2(ROW_LIMIT + 1);
  localparam int OFF_W       = RW + 4;

  typedef enum logic [1:0] {S_IDLE, S_WIDTH, S_ROWS} state_e;

  // Configuration registers
  logic [5:0]  font_h_q;
  logic [2:0]  row_bytes_q;
  logic [11:0] screen_w_q;
  logic [11:0] screen_h_q;
  logic [15:0] bg_q;
  logic [15:0] key_q;

  // Cursor and sequencer state
  state_e          state_q;
  logic [12:0]     cur_x_q, cur_y_q, span_x_q;
  logic [11:0]     org_x_q, org_y_q;
  logic [5:0]      prev_w_q, width_q;
  logic            active_q;
  logic [RW-1:0]   row_q, rows_q;
  logic [PIX_W-1:0] wmask_q;
  logic [BAW-1:0]  glyph_base_q;

  logic            in_xfer;
  logic [6:0]      draw_slot;
  logic            draw_ok;
  logic            width_wr, bitmap_wr;
  logic [5:0]      width_wdata;
  logic [BAW-1:0]  bitmap_waddr;

  logic [13:0]     cx_sum;
  logic            wrap_line, wrap_page;
  logic [12:0]     cx1, cy1;

  logic [5:0]      width_rd;
  logic [PIX_W-1:0] wmask_new;
  logic [RW-1:0]   rows_new;

  logic [2:0]      rb_eff;
  logic [OFF_W-1:0] row_base;
  logic [OFF_W-1:0] off_b [BANKS];
  logic [BANKS-1:0] byte_ok;
  logic [BANKS-1:0][BAW-1:0] bank_addr;
  logic [BANKS-1:0][7:0]     bank_data;

  logic            span_free, issue;
  span_req_t       req;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;

  // Loads
  assign width_wr    = in_xfer && (mode_e'(mode_i) == MODE_WIDTH) &&
                       (int'(glyph_slot_i) < GLYPH_COUNT);
  assign width_wdata = (load_value_i > WIDTH_SAT) ? 6'(WIDTH_SAT) : 6'(load_value_i);
  assign bitmap_wr   = in_xfer && (mode_e'(mode_i) == MODE_BITMAP) &&
                       (int'(glyph_slot_i) < GLYPH_COUNT) &&
                       (int'(byte_offset_i) < GLYPH_BYTES);
  assign bitmap_waddr = BAW'(int'(glyph_slot_i) * WPG) + BAW'(byte_offset_i[6:2]);

  // Draw qualification
  assign draw_slot = char_code_i - CODE_SPACE;
  assign draw_ok   = in_xfer && (mode_e'(mode_i) == MODE_DRAW) && active_q &&
                     (char_code_i >= CODE_SPACE) && (int'(draw_slot) < GLYPH_COUNT);

  // Wrap uses the width of the glyph drawn before
  always_comb begin
    cx_sum    = 14'(cur_x_q) + 14'(prev_w_q);
    wrap_line = cx_sum > 14'(screen_w_q);
    cx1       = wrap_line ? 13'(org_x_q) : cur_x_q;
    cy1       = wrap_line ? 13'(cur_y_q + 13'(font_h_q)) : cur_y_q;
    wrap_page = (14'(cy1) + 14'(font_h_q)) > 14'(screen_h_q);
  end

  always_comb begin
    wmask_new = (width_rd >= 6'd32) ? '1 : ~({PIX_W{1'b1}} >> width_rd);
    rows_new  = (int'(font_h_q) > ROW_LIMIT) ? RW'(ROW_LIMIT) : RW'(font_h_q);
  end

  // Per-row byte validity and bank addresses
  always_comb begin
    logic [1:0] bidx;
    rb_eff   = (int'(row_bytes_q) > MAX_ROW_BYTES) ? 3'(MAX_ROW_BYTES) : row_bytes_q;
    row_base = OFF_W'(row_q) * OFF_W'(rb_eff);
    for (int b = 0; b < BANKS; b++) begin
      off_b[b]   = row_base + OFF_W'(b);
      byte_ok[b] = (3'(b) < rb_eff) && (int'(off_b[b]) < STORE_BYTES);
    end
    for (int k = 0; k < BANKS; k++) begin
      bidx = 2'(k) - row_base[1:0];
      bank_addr[k] = byte_ok[bidx] ? glyph_base_q + BAW'(off_b[bidx] >> 2) : glyph_base_q;
    end
  end

  assign issue = (state_q == S_ROWS) && span_free;

  always_comb begin
    req.x       = span_x_q;
    req.y       = cur_y_q + 13'(row_q);
    req.width   = width_q;
    req.wmask   = wmask_q;
    req.byte_ok = byte_ok;
    req.base_lo = row_base[1:0];
    req.opaque  = (bg_q != key_q);
    req.last    = (row_q == rows_q - RW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_h_q    <= 6'd24;
      row_bytes_q <= 3'd3;
      screen_w_q  <= 12'd800;
      screen_h_q  <= 12'd480;
      bg_q        <= 16'hFFFF;
      key_q       <= 16'hFFFF;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FONT_HEIGHT: font_h_q    <= cfg_data_i[5:0];
        CFG_ROW_BYTES:   row_bytes_q <= cfg_data_i[2:0];
        CFG_SCREEN_W:    screen_w_q  <= cfg_data_i[11:0];
        CFG_SCREEN_H:    screen_h_q  <= cfg_data_i[11:0];
        CFG_BACKGROUND:  bg_q        <= cfg_data_i;
        CFG_KEY:         key_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      org_x_q      <= '0;
      org_y_q      <= '0;
      prev_w_q     <= '0;
      active_q     <= 1'b0;
      row_q        <= '0;
      rows_q       <= '0;
      span_x_q     <= '0;
      width_q      <= '0;
      wmask_q      <= '0;
      glyph_base_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_xfer && (mode_e'(mode_i) == MODE_START)) begin
            if ((start_x_i > screen_w_q) || (start_y_i > screen_h_q)) begin
              active_q <= 1'b0;
            end else begin
              org_x_q  <= start_x_i;
              org_y_q  <= start_y_i;
              cur_x_q  <= 13'(start_x_i);
              cur_y_q  <= 13'(start_y_i);
              prev_w_q <= '0;
              active_q <= 1'b1;
            end
          end
          if (draw_ok) begin
            cur_x_q      <= wrap_page ? 13'(org_x_q) : cx1;
            cur_y_q      <= wrap_page ? 13'(org_y_q) : cy1;
            glyph_base_q <= BAW'(int'(draw_slot) * WPG);
            state_q      <= S_WIDTH;
          end
        end
        S_WIDTH: begin
          span_x_q <= cur_x_q;
          cur_x_q  <= cur_x_q + 13'(width_rd);
          prev_w_q <= width_rd;
          width_q  <= width_rd;
          wmask_q  <= wmask_new;
          rows_q   <= rows_new;
          row_q    <= '0;
          state_q  <= (rows_new == '0) ? S_IDLE : S_ROWS;
        end
        S_ROWS: begin
          if (issue) begin
            row_q <= row_q + RW'(1);
            if (req.last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  vwtr_width_mem #(
    .DEPTH (GLYPH_COUNT),
    .AW    (SW)
  ) u_width_mem (
    .clk_i     (clk_i),
    .wr_en_i   (width_wr),
    .wr_addr_i (SW'(glyph_slot_i)),
    .wr_data_i (width_wdata),
    .rd_en_i   (draw_ok),
    .rd_addr_i (SW'(draw_slot)),
    .rd_data_o (width_rd)
  );

  vwtr_bitmap_mem #(
    .DEPTH (BANK_DEPTH),
    .AW    (BAW)
  ) u_bitmap_mem (
    .clk_i     (clk_i),
    .wr_en_i   (bitmap_wr),
    .wr_bank_i (byte_offset_i[1:0]),
    .wr_addr_i (bitmap_waddr),
    .wr_data_i (load_value_i),
    .rd_en_i   (issue),
    .rd_addr_i (bank_addr),
    .rd_data_o (bank_data)
  );

  vwtr_span_out u_span_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (issue),
    .req_i        (req),
    .bank_data_i  (bank_data),
    .req_free_o   (span_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .span_x_o     (span_x_o),
    .span_y_o     (span_y_o),
    .span_width_o (span_width_o),
    .pixel_mask_o (pixel_mask_o),
    .opaque_o     (opaque_o),
    .last_row_o   (last_row_o)
  );

  // Row counter never runs past the row count of the glyph
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROWS) |-> (row_q < rows_q))
    else $error("row counter past glyph row count");

  // A printable character of an active string always goes through the width fetch
  a_draw_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draw_ok |=> (state_q == S_WIDTH))
    else $error("draw item did not fetch glyph width");

  // No pixel set at or beyond the span width
  a_mask_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (span_width_o < 6'd32)) |-> ((pixel_mask_o << span_width_o) == '0))
    else $error("pixel mask wider than span");

endmodule

FILE: hdl/vwtr_width_mem.sv
// Glyph width table: one write port, one registered read port.
// Depends on nothing; instantiated by variable_width_text_renderer.
module vwtr_width_mem #(
  parameter int DEPTH = 96,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [5:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [5:0]    rd_data_o
);

  logic [5:0] mem [DEPTH];
  logic [5:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rdata_q;

endmodule

FILE: hdl/vwtr_bitmap_mem.sv
// Glyph bitmap store, split into byte banks by offset modulo BANKS so that
// any run of BANKS consecutive bytes of a glyph reads in a single access.
// Depends on vwtr_pkg.
module vwtr_bitmap_mem
  import vwtr_pkg::*;
#(
  parameter int DEPTH = 3072,
  parameter int AW    = 12
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [1:0]                 wr_bank_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [7:0]                 wr_data_i,
  input  logic                       rd_en_i,
  input  logic [BANKS-1:0][AW-1:0]   rd_addr_i,
  output logic [BANKS-1:0][7:0]      rd_data_o
);

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == 2'(k))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rdata_q <= mem[rd_addr_i[k]];
      end
    end

    assign rd_data_o[k] = rdata_q;
  end

endmodule

FILE: hdl/vwtr_span_out.sv
// Row assembly and output register: holds the row whose bank data sits in
// the memory read registers, builds the pixel mask, drives the result port.
// Depends on vwtr_pkg.
module vwtr_span_out
  import vwtr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  span_req_t             req_i,
  input  logic [BANKS-1:0][7:0] bank_data_i,
  output logic                  req_free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [12:0]           span_x_o,
  output logic [12:0]           span_y_o,
  output logic [5:0]            span_width_o,
  output logic [PIX_W-1:0]      pixel_mask_o,
  output logic                  opaque_o,
  output logic                  last_row_o
);

  logic             hold_q;
  span_req_t        req_q;
  logic             out_valid_q;
  logic             move;
  logic [PIX_W-1:0] mask_raw;
  logic [PIX_W-1:0] mask;

  // Bank data stays put until the next read, so the held row can wait
  assign move       = hold_q && (!out_valid_q || out_ready_i);
  assign req_free_o = !hold_q || move;

  always_comb begin
    logic [1:0] sel;
    mask_raw = '0;
    for (int b = 0; b < BANKS; b++) begin
      sel = 2'(b) + req_q.base_lo;
      mask_raw[PIX_W-1-8*b -: 8] = bank_data_i[sel] & {8{req_q.byte_ok[b]}};
    end
    mask = mask_raw & req_q.wmask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_valid_i) begin
        hold_q <= 1'b1;
      end else if (move) begin
        hold_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      req_q <= req_i;
    end
    if (move) begin
      span_x_o     <= req_q.x;
      span_y_o     <= req_q.y;
      span_width_o <= req_q.width;
      pixel_mask_o <= mask;
      opaque_o     <= req_q.opaque;
      last_row_o   <= req_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: dv/variable_width_text_renderer_tb.sv
// Self-checking bench for variable_width_text_renderer: glyph loads, string starts and
// character draws, with every row span predicted in order and compared field by field.
// Depends on vwtr_pkg and the RTL of the block.
module variable_width_text_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vwtr_pkg::*;

  localparam int GLYPHS       = 96;
  localparam int ROWS_MAX     = 32;
  localparam int RB_MAX       = 4;
  localparam int GLYPH_BYTES  = ROWS_MAX * RB_MAX;
  localparam int DRAIN_CYCLES = 40;      // idle margin after the last expected span
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    mode_e       mode;
    logic [6:0]  slot;
    logic [6:0]  offset;
    logic [7:0]  value;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [6:0]  code;
  } glyph_item_t;

  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [5:0]  width;
    logic [31:0] mask;
    logic        opaque;
    logic        last;
  } span_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i        = '0;
  logic [6:0]  glyph_slot_i  = '0;
  logic [6:0]  byte_offset_i = '0;
  logic [7:0]  load_value_i  = '0;
  logic [11:0] start_x_i     = '0;
  logic [11:0] start_y_i     = '0;
  logic [6:0]  char_code_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [12:0] span_x_o;
  logic [12:0] span_y_o;
  logic [5:0]  span_width_o;
  logic [31:0] pixel_mask_o;
  logic        opaque_o;
  logic        last_row_o;

  variable_width_text_renderer #(
    .GLYPH_COUNT  (GLYPHS),
    .MAX_ROWS     (ROWS_MAX),
    .MAX_ROW_BYTES(RB_MAX)
  ) DUT (.*);

  always #1 clk_i = ~clk_i;

  // Mirror of the font, cursor and registers
  logic [5:0]  glyph_w    [GLYPHS];
  logic [7:0]  glyph_bits [GLYPHS][GLYPH_BYTES];
  bit          w_known    [GLYPHS];
  bit          bits_known [GLYPHS][GLYPH_BYTES];
  logic [12:0] cur_x      = '0;
  logic [12:0] cur_y      = '0;
  logic [11:0] org_x      = '0;
  logic [11:0] org_y      = '0;
  logic [5:0]  prev_w     = '0;
  bit          str_on     = 1'b0;
  logic [5:0]  font_h     = 6'd24;
  logic [2:0]  row_b      = 3'd3;
  logic [11:0] scr_w      = 12'd800;
  logic [11:0] scr_h      = 12'd480;
  logic [15:0] bg_color   = 16'hFFFF;
  logic [15:0] key_color  = 16'hFFFF;

  span_t       pending_spans[$];
  int unsigned fault_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned in_gap_max    = 10;
  int unsigned out_stall_max = 10;
  logic        out_hold      = 1'b0;
  event        hold_kick;
  logic [6:0]  common_codes [8] = '{7'h20, 7'h21, 7'h41, 7'h4D, 7'h5A, 7'h61, 7'h7A, 7'h7F};

  function automatic void predict_spans(glyph_item_t it);
    int unsigned slot, w, rows, rbe, off, col;
    logic [31:0] mask;
    span_t       s;
    case (it.mode)
      MODE_WIDTH: begin
        if (it.slot < GLYPHS) begin
          glyph_w[it.slot] = (it.value > WIDTH_SAT) ? 6'(WIDTH_SAT) : it.value[5:0];
          w_known[it.slot] = 1'b1;
        end
      end
      MODE_BITMAP: begin
        if (it.slot < GLYPHS && it.offset < GLYPH_BYTES) begin
          glyph_bits[it.slot][it.offset] = it.value;
          bits_known[it.slot][it.offset] = 1'b1;
        end
      end
      MODE_START: begin
        if (it.sx > scr_w || it.sy > scr_h) begin
          str_on = 1'b0;
        end else begin
          org_x  = it.sx;
          org_y  = it.sy;
          cur_x  = 13'(it.sx);
          cur_y  = 13'(it.sy);
          prev_w = '0;
          str_on = 1'b1;
        end
      end
      default: begin
        if (!str_on || it.code < CODE_SPACE || (it.code - CODE_SPACE) >= GLYPHS) return;
        slot = it.code - CODE_SPACE;
        // width test uses the glyph drawn before this one
        if (int'(cur_x) + int'(prev_w) > int'(scr_w)) begin
          cur_x = 13'(org_x);
          cur_y = cur_y + 13'(font_h);
        end
        if (int'(cur_y) + int'(font_h) > int'(scr_h)) begin
          cur_x = 13'(org_x);
          cur_y = 13'(org_y);
        end
        w    = glyph_w[slot];
        rows = (font_h < ROWS_MAX) ? font_h : ROWS_MAX;
        rbe  = (row_b < RB_MAX) ? row_b : RB_MAX;
        for (int r = 0; r < rows; r++) begin
          mask = '0;
          for (col = 0; col < w; col++) begin
            off = r * rbe + col / 8;
            if (col / 8 < rbe && off < GLYPH_BYTES && glyph_bits[slot][off][7 - col % 8])
              mask[31 - col] = 1'b1;
          end
          s.x      = cur_x;
          s.y      = cur_y + 13'(r);
          s.width  = 6'(w);
          s.mask   = mask;
          s.opaque = (bg_color != key_color);
          s.last   = (r == rows - 1);
          pending_spans.push_back(s);
        end
        cur_x  = cur_x + 13'(w);
        prev_w = 6'(w);
      end
    endcase
  endfunction

  function automatic glyph_item_t random_item(mode_e m);
    glyph_item_t it;
    it.mode   = m;
    it.slot   = 7'($urandom);
    it.offset = 7'($urandom);
    it.value  = 8'($urandom);
    it.sx     = 12'($urandom);
    it.sy     = 12'($urandom);
    it.code   = 7'($urandom);
    return it;
  endfunction

  function automatic void note_fault(string what, span_t want, span_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("%s: exp x=%0d y=%0d w=%0d mask=%08h op=%0b last=%0b | got x=%0d y=%0d w=%0d mask=%08h op=%0b last=%0b",
               what, want.x, want.y, want.width, want.mask, want.opaque, want.last,
               got.x, got.y, got.width, got.mask, got.opaque, got.last);
  endfunction

  // Valid is only dropped when a gap follows, so back-to-back transfers keep it high
  task automatic offer_item(input glyph_item_t it);
    int unsigned gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= it.mode;
    glyph_slot_i  <= it.slot;
    byte_offset_i <= it.offset;
    load_value_i  <= it.value;
    start_x_i     <= it.sx;
    start_y_i     <= it.sy;
    char_code_i   <= it.code;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_spans(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_FONT_HEIGHT: font_h    = data[5:0];
      CFG_ROW_BYTES:   row_b     = data[2:0];
      CFG_SCREEN_W:    scr_w     = data[11:0];
      CFG_SCREEN_H:    scr_h     = data[11:0];
      CFG_BACKGROUND:  bg_color  = data;
      CFG_KEY:         key_color = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [5:0] fh, input logic [2:0] rb,
                              input logic [11:0] sw, input logic [11:0] sh,
                              input logic [15:0] bg, input logic [15:0] key);
    wait_drained();
    write_reg(CFG_FONT_HEIGHT, 16'(fh));
    write_reg(CFG_ROW_BYTES, 16'(rb));
    write_reg(CFG_SCREEN_W, 16'(sw));
    write_reg(CFG_SCREEN_H, 16'(sh));
    write_reg(CFG_BACKGROUND, bg);
    write_reg(CFG_KEY, key);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_width(input logic [6:0] slot, input logic [7:0] value);
    glyph_item_t it;
    it       = random_item(MODE_WIDTH);
    it.slot  = slot;
    it.value = value;
    offer_item(it);
  endtask

  task automatic load_byte(input logic [6:0] slot, input logic [6:0] off, input logic [7:0] value);
    glyph_item_t it;
    it        = random_item(MODE_BITMAP);
    it.slot   = slot;
    it.offset = off;
    it.value  = value;
    offer_item(it);
  endtask

  task automatic start_string(input logic [11:0] x, input logic [11:0] y);
    glyph_item_t it;
    it    = random_item(MODE_START);
    it.sx = x;
    it.sy = y;
    offer_item(it);
  endtask

  // Font memories have no reset: fill whatever this draw could read first
  task automatic prepare_glyph(input logic [6:0] code);
    int unsigned slot, rows, rbe, off;
    if (code < CODE_SPACE) return;
    slot = code - CODE_SPACE;
    if (!w_known[slot]) load_width(7'(slot), 8'($urandom_range(0, 40)));
    rows = (font_h < ROWS_MAX) ? font_h : ROWS_MAX;
    rbe  = (row_b < RB_MAX) ? row_b : RB_MAX;
    for (int r = 0; r < rows; r++) begin
      for (int b = 0; b < rbe; b++) begin
        off = r * rbe + b;
        if (off < GLYPH_BYTES && !bits_known[slot][off])
          load_byte(7'(slot), 7'(off), 8'($urandom));
      end
    end
  endtask

  task automatic draw_char(input logic [6:0] code);
    glyph_item_t it;
    prepare_glyph(code);
    it      = random_item(MODE_DRAW);
    it.code = code;
    offer_item(it);
  endtask

  task automatic test_reset_defaults();
    draw_char(7'h41);            // no string yet
    load_width(7'd33, 8'd12);
    start_string(12'd0, 12'd0);
    draw_char(7'h41);
    draw_char(7'h1F);            // below space
    draw_char(7'h00);
    load_width(7'd95, 8'd255);   // saturates
    draw_char(7'h7F);
    draw_char(7'h41);
  endtask

  task automatic test_start_bounds();
    start_string(12'd801, 12'd0);
    draw_char(7'h41);
    start_string(12'd0, 12'd481);
    start_string(12'd800, 12'd480);   // on the edge: accepted, bottom wraps to origin
    draw_char(7'h41);
    draw_char(7'h4D);
    start_string(12'd4095, 12'd4095);
    draw_char(7'h41);
  endtask

  task automatic test_load_edges();
    load_width(7'd96, 8'd5);
    load_byte(7'd127, 7'd127, 8'hFF);
    load_width(7'd0, 8'd0);
    load_byte(7'd0, 7'd127, 8'hA5);
    start_string(12'd0, 12'd0);
    draw_char(7'h20);            // zero-width glyph still emits rows
    load_width(7'd0, 8'd32);
    draw_char(7'h20);
    load_width(7'd1, 8'd33);
    draw_char(7'h21);
    wait_drained();
  endtask

  task automatic run_phase(input logic [5:0] fh, input logic [2:0] rb,
                           input logic [11:0] sw, input logic [11:0] sh,
                           input logic [15:0] bg, input logic [15:0] key,
                           input int unsigned in_gap, input int unsigned out_stall,
                           input int unsigned n);
    int unsigned counted, pick;
    glyph_item_t it;
    apply_config(fh, rb, sw, sh, bg, key);
    in_gap_max    = in_gap;
    out_stall_max = out_stall;
    counted       = 0;
    start_string(12'($urandom_range(0, scr_w)), 12'($urandom_range(0, scr_h)));
    while (counted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        start_string(12'($urandom_range(0, scr_w)), 12'($urandom_range(0, scr_h)));
        counted++;
      end else if (pick < 14) begin
        it = random_item(MODE_START);
        offer_item(it);
        if (str_on) counted++;
      end else if (pick < 22) begin
        it = random_item(pick < 18 ? MODE_WIDTH : MODE_BITMAP);
        offer_item(it);
        if (it.slot < GLYPHS) counted++;
      end else if (pick < 28) begin
        draw_char(7'($urandom_range(0, 31)));
      end else if (pick < 33) begin
        draw_char(7'($urandom_range(32, 127)));
        if (str_on) counted++;
      end else begin
        draw_char(common_codes[$urandom_range(0, 7)]);
        if (str_on) counted++;
      end
    end
  endtask

  task automatic test_random_phases();
    run_phase(6'd32, 3'd4, 12'd4095, 12'd4095, 16'h0000, 16'hFFFF, 10, 10, 22);
    run_phase(6'd1, 3'd1, 12'd1, 12'd1, 16'd123, 16'd123, 10, 0, 22);
    run_phase(6'd8, 3'd2, 12'd60, 12'd40, 16'hFFFF, 16'h0000, 0, 0, 22);
    run_phase(6'd16, 3'd4, 12'd200, 12'd100, 16'($urandom), 16'($urandom), 3, 10, 22);
    run_phase(6'd5, 3'd3, 12'd4095, 12'd30, 16'h5555, 16'h5555, 10, 10, 22);
  endtask

  task automatic test_backpressure();
    apply_config(6'd32, 3'd4, 12'd4095, 12'd4095, 16'h0000, 16'h0001);
    in_gap_max    = 0;
    out_stall_max = 0;
    start_string(12'd0, 12'd0);
    for (int i = 0; i < 8; i++) prepare_glyph(common_codes[i]);
    -> hold_kick;
    for (int i = 0; i < 10; i++) draw_char(common_codes[i % 8]);
    wait_drained();
  endtask

  // Long receiver hold-off, counted here so the sender keeps offering
  initial begin : hold_window
    forever begin
      @(hold_kick);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      out_hold <= 1'b0;
    end
  end

  initial begin : span_sink
    int unsigned stall;
    span_t       got, want;
    forever begin
      stall = (out_stall_max > 0) ? $urandom_range(0, out_stall_max) : 0;
      if (stall > 0 || out_hold) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (out_hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = '{span_x_o, span_y_o, span_width_o, pixel_mask_o, opaque_o, last_row_o};
      if (pending_spans.size() == 0) begin
        note_fault("unexpected span", '0, got);
      end else begin
        want = pending_spans.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.width !== want.width ||
            got.mask !== want.mask || got.opaque !== want.opaque || got.last !== want.last)
          note_fault("span mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : regression
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_start_bounds();
    test_load_edges();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (fault_count == 0 && pending_spans.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/vwtr_pkg.sv
hdl/vwtr_width_mem.sv
hdl/vwtr_bitmap_mem.sv
hdl/vwtr_span_out.sv
hdl/variable_width_text_renderer.sv
dv/variable_width_text_renderer_tb.sv
